@@ sv/mhpcf_pkg.sv @@
`timescale 1ns / 1ps

package mhpcf_pkg;

  // default upper bound on the module size
  localparam int DEF_MAX_MODULE_BYTES = 256;

  // header layout and check values
  localparam logic [7:0] SYNC_BYTE0     = 8'h4A;
  localparam logic [7:0] SYNC_BYTE1     = 8'hFC;
  localparam int         SIZE_POS_FIRST = 4;
  localparam int         SIZE_POS_LAST  = 7;
  localparam int         PARITY_POS     = 'h2E;
  localparam int         MIN_MODULE_BYTES = 51;
  localparam logic [23:0] CRC_INIT      = 24'hFFFFFF;
  localparam logic [7:0]  CRC_TOP_FIX   = 8'h80;
  localparam logic [7:0]  CRC_LOW_FIX   = 8'h21;

  typedef struct packed {
    logic [7:0] module_byte;
    logic       start_of_module;
  } in_beat_t;

  typedef struct packed {
    logic       valid;
    in_beat_t   beat;
  } stage_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
    logic       header_error;
  } res_beat_t;

  // one byte of the 24-bit module crc
  function automatic logic [23:0] crc_update(input logic [23:0] crc, input logic [7:0] b);
    logic [7:0] a;
    logic [7:0] n0;
    logic [7:0] n1;
    logic [7:0] n2;
    a  = b ^ crc[23:16];
    n0 = crc[15:8];
    n1 = crc[7:0] ^ (a >> 7) ^ (a >> 2);
    n2 = (a << 1) ^ (a << 6);
    if (^a) begin
      n0 = n0 ^ CRC_TOP_FIX;
      n2 = n2 ^ CRC_LOW_FIX;
    end
    return {n0, n1, n2};
  endfunction

endpackage

@@ sv/mhpcf_ifs.sv @@
`timescale 1ns / 1ps

// input byte channel
interface mhpcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] module_byte;
  logic       start_of_module;
  modport source (output valid, output module_byte, output start_of_module, input ready);
  modport sink   (input valid, input module_byte, input start_of_module, output ready);
endinterface

// result byte channel
interface mhpcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_last;
  logic       header_error;
  modport source (output valid, output out_byte, output is_last, output header_error,
                  input ready);
  modport sink   (input valid, input out_byte, input is_last, input header_error,
                  output ready);
endinterface

@@ sv/mhpcf_in_reg.sv @@
`timescale 1ns / 1ps

module mhpcf_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mhpcf_pkg::in_beat_t in_beat,
  input  logic              advance,
  output mhpcf_pkg::stage_t stage
);
  import mhpcf_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_beat_t beat_r;

  // take a new beat when empty or when the held one moves on
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign stage.valid = valid_r;
  assign stage.beat  = beat_r;
endmodule

@@ sv/mhpcf_fixup.sv @@
`timescale 1ns / 1ps

module mhpcf_fixup #(
  parameter int MAX_MODULE_BYTES = mhpcf_pkg::DEF_MAX_MODULE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  mhpcf_pkg::in_beat_t  beat,
  output mhpcf_pkg::res_beat_t result
);
  import mhpcf_pkg::*;

  localparam int POS_W = $clog2(MAX_MODULE_BYTES + 1);
  localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_MODULE_BYTES);
  localparam logic [31:0]      MAX_SIZE = 32'(MAX_MODULE_BYTES);
  localparam logic [31:0]      MIN_SIZE = 32'(MIN_MODULE_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [31:0]      size_r, size_nxt, size_cur;
  logic [15:0]      par_r, par_nxt, par_cur;
  logic [23:0]      crc_r, crc_nxt, crc_cur;
  logic             bad_r, bad_nxt, bad_cur;

  logic [7:0]  b;
  logic [7:0]  ob;
  logic [31:0] pos_ext;
  logic [31:0] tail_start;
  logic [1:0]  tail_idx;
  logic [23:0] crc_fin;
  logic        in_range;
  logic        active;
  logic        checked;
  logic        past_end;
  logic        in_tail;
  logic        last;

  // a start mark puts the state back to its reset values first
  always_comb begin
    pos_cur  = beat.start_of_module ? '0 : pos_r;
    size_cur = beat.start_of_module ? '0 : size_r;
    par_cur  = beat.start_of_module ? '0 : par_r;
    crc_cur  = beat.start_of_module ? CRC_INIT : crc_r;
    bad_cur  = beat.start_of_module ? 1'b0 : bad_r;
  end

  assign b        = beat.module_byte;
  assign pos_ext  = 32'(pos_cur);
  assign in_range = pos_cur < MAX_POS;
  assign active   = !bad_cur && in_range;

  // size pickup and header checks
  always_comb begin
    size_nxt = size_cur;
    if (active && pos_cur >= POS_W'(SIZE_POS_FIRST) && pos_cur <= POS_W'(SIZE_POS_LAST)) begin
      size_nxt = {size_cur[23:0], b};
    end
    bad_nxt = bad_cur;
    if (active) begin
      if (pos_cur == '0 && b != SYNC_BYTE0) begin
        bad_nxt = 1'b1;
      end
      if (pos_cur == POS_W'(1) && b != SYNC_BYTE1) begin
        bad_nxt = 1'b1;
      end
      if (pos_cur == POS_W'(SIZE_POS_LAST) && (size_nxt < MIN_SIZE || size_nxt > MAX_SIZE)) begin
        bad_nxt = 1'b1;
      end
    end
  end

  assign checked    = !bad_nxt && in_range;
  assign tail_start = size_nxt - 32'd3;
  assign past_end   = pos_cur >= POS_W'(8) && pos_ext >= size_nxt;
  assign in_tail    = pos_cur >= POS_W'(8) && pos_ext >= tail_start;
  assign tail_idx   = 2'(pos_ext - tail_start);
  assign crc_fin    = ~crc_cur;

  // parity and crc accumulation and byte replacement
  always_comb begin
    ob      = b;
    par_nxt = par_cur;
    crc_nxt = crc_cur;
    last    = 1'b0;
    if (checked) begin
      if (pos_cur < POS_W'(PARITY_POS)) begin
        par_nxt = par_cur ^ (pos_cur[0] ? {8'h00, b} : {b, 8'h00});
      end else if (pos_cur == POS_W'(PARITY_POS)) begin
        ob = ~par_cur[15:8];
      end else if (pos_cur == POS_W'(PARITY_POS + 1)) begin
        ob = ~par_cur[7:0];
      end
      if (past_end) begin
        ob = b;
      end else if (in_tail) begin
        unique case (tail_idx)
          2'd0:    ob = crc_fin[23:16];
          2'd1:    ob = crc_fin[15:8];
          default: ob = crc_fin[7:0];
        endcase
        last = tail_idx == 2'd2;
      end else begin
        crc_nxt = crc_update(crc_cur, ob);
      end
    end
  end

  assign pos_nxt = in_range ? pos_cur + POS_W'(1) : pos_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      size_r <= '0;
      par_r  <= '0;
      crc_r  <= CRC_INIT;
      bad_r  <= 1'b0;
    end else if (fire) begin
      pos_r  <= pos_nxt;
      size_r <= size_nxt;
      par_r  <= par_nxt;
      crc_r  <= crc_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign result.out_byte     = ob;
  assign result.is_last      = last;
  assign result.header_error = bad_nxt;
endmodule

@@ sv/mhpcf_out_reg.sv @@
`timescale 1ns / 1ps

module mhpcf_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  mhpcf_pkg::res_beat_t result,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 can_load,
  output mhpcf_pkg::res_beat_t out_beat
);
  import mhpcf_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  res_beat_t beat_r;

  // room when empty or when the held beat leaves this cycle
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;
endmodule

@@ sv/module_header_parity_crc_fixup.sv @@
`timescale 1ns / 1ps

// channel   direction  payload
// in_chan   sink       module_byte[7:0], start_of_module
// out_chan  source     out_byte[7:0], is_last, header_error
//
// one byte per cycle sustained while out_chan.ready stays high
// a taken byte is registered in the input register and then in the result register
// synchronous active-low reset empties both registers and clears the check state
// a stalled output holds its beat while one more input beat waits in the input register

module module_header_parity_crc_fixup #(
  parameter int MAX_MODULE_BYTES = mhpcf_pkg::DEF_MAX_MODULE_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  mhpcf_in_if.sink           in_chan,
  mhpcf_out_if.source        out_chan
);
  import mhpcf_pkg::*;

  in_beat_t  in_beat;
  stage_t    stage;
  res_beat_t result;
  res_beat_t out_beat;
  logic      can_load;
  logic      fire;

  assign in_beat.module_byte     = in_chan.module_byte;
  assign in_beat.start_of_module = in_chan.start_of_module;

  // a held beat is processed when the result register has room
  assign fire = stage.valid && can_load;

  mhpcf_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_beat  (in_beat),
    .advance  (fire),
    .stage    (stage)
  );

  mhpcf_fixup #(
    .MAX_MODULE_BYTES (MAX_MODULE_BYTES)
  ) u_fixup (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .beat   (stage.beat),
    .result (result)
  );

  mhpcf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .result    (result),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .can_load  (can_load),
    .out_beat  (out_beat)
  );

  assign out_chan.out_byte     = out_beat.out_byte;
  assign out_chan.is_last      = out_beat.is_last;
  assign out_chan.header_error = out_beat.header_error;

  // the last byte of a module never comes with a bad header
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !(out_chan.is_last && out_chan.header_error))
    else $error("is_last set on a beat with header_error");

  // an empty result register never stalls the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_chan.valid |-> in_chan.ready)
    else $error("input stalled with empty result register");

  // an accepted beat is held in the input register next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> stage.valid)
    else $error("accepted beat lost");

  // processing a beat always leaves a result waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_chan.valid)
    else $error("processed beat not presented");
endmodule
